/* rtl/core/rgb_histogram_with_mean_rotation_unit_assert.svh */
// Assertion macros for the RGB histogram block.
`ifndef RGB_HISTOGRAM_WITH_MEAN_ROTATION_UNIT_ASSERT_SVH
`define RGB_HISTOGRAM_WITH_MEAN_ROTATION_UNIT_ASSERT_SVH

`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define RGBH_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rgbh assertion failed");
// Check that cons holds in the cycle after ante.
`define RGBH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rgbh assertion failed");
`else
`define RGBH_ASSERT_NOW(label, clk, rstn, ante, cons)
`define RGBH_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/rgbh_pkg.sv */
// Shared types and constants of the RGB histogram block.
`default_nettype none

package rgbh_pkg;

  localparam int unsigned VALUE_W     = 8;
  localparam int unsigned VALUE_RANGE = 256;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned PIX_CNT_W   = 24;
  localparam int unsigned OUT_CNT_W   = 24;
  localparam int unsigned CNT_WIDE_W  = 32;
  localparam int unsigned MEAN_W      = 8;
  localparam int unsigned QUO_STEP_W  = 3;
  localparam int unsigned NUM_CHAN    = 3;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 104;
  localparam int unsigned OUT_TUSER_W = 1;

  localparam logic [PIX_CNT_W-1:0] PIX_CNT_MAX = {PIX_CNT_W{1'b1}};

  typedef enum logic [IN_TUSER_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_PIXEL  = 3'd1,
    KIND_FINISH = 3'd2,
    KIND_ROTATE = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_RUN   = 2'd1,
    ST_DIV   = 2'd2
  } state_e;

  // Per-cycle control of one histogram channel.
  typedef struct packed {
    logic rd_en;   // issue a bin read this cycle
    logic bump;    // the read belongs to a pixel: increment and write back
    logic clr_en;  // clearing pass writes zero this cycle
  } bin_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/rgbh_ram.sv */
// Simple dual-port bin memory: one write port, one registered read port.
`default_nettype none

module rgbh_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rgbh_bin_rmw.sv */
// One histogram channel: bin memory with read-modify-write and forwarding.
`default_nettype none

module rgbh_bin_rmw
  import rgbh_pkg::*;
#(
  parameter int unsigned BIN_COUNT  = 256,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bin_ctrl_t                    ctrl_i,
  input  wire logic [$clog2(BIN_COUNT)-1:0] rd_addr_i,
  input  wire logic [$clog2(BIN_COUNT)-1:0] clr_addr_i,
  output logic      [COUNT_BITS-1:0]        count_o
);

  localparam int unsigned IDX_W = $clog2(BIN_COUNT);
  localparam logic [COUNT_BITS-1:0] BIN_MAX = {COUNT_BITS{1'b1}};

  logic                  s2_bump_q;
  logic [IDX_W-1:0]      s2_addr_q;
  logic                  fwd_valid_q, fwd_valid_d;
  logic [IDX_W-1:0]      fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] bumped;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [COUNT_BITS-1:0] wdata;

  rgbh_ram #(
    .DEPTH (BIN_COUNT),
    .WIDTH (COUNT_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  // The write of the previous cycle is not yet visible in the read data.
  assign count_o = (fwd_valid_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q : ram_rdata;
  assign bumped  = (count_o == BIN_MAX) ? count_o : count_o + 1'b1;

  always_comb begin
    we          = 1'b0;
    waddr       = s2_addr_q;
    wdata       = bumped;
    fwd_valid_d = 1'b0;
    if (ctrl_i.clr_en) begin
      we    = 1'b1;
      waddr = clr_addr_i;
      wdata = '0;
    end else if (s2_bump_q) begin
      we          = 1'b1;
      fwd_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_bump_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s2_bump_q   <= ctrl_i.rd_en & ctrl_i.bump;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_addr_q  <= rd_addr_i;
    fwd_addr_q <= s2_addr_q;
    fwd_data_q <= bumped;
  end

endmodule

`default_nettype wire

/* rtl/core/rgbh_mean_div.sv */
// Three-lane restoring divider for the per-channel means, one quotient bit a cycle.
`default_nettype none

module rgbh_mean_div
  import rgbh_pkg::*;
(
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [NUM_CHAN-1:0][SUM_W-1:0]   sum_i,
  input  wire logic [PIX_CNT_W-1:0]             count_i,
  output logic                                  done_o,
  output logic      [NUM_CHAN-1:0][MEAN_W-1:0]  mean_o
);

  localparam int unsigned PAD_W = SUM_W - PIX_CNT_W - (MEAN_W - 1);

  logic                              run_q;
  logic                              done_q;
  logic [QUO_STEP_W-1:0]             step_q;
  logic [SUM_W-1:0]                  div_q;
  logic [NUM_CHAN-1:0][SUM_W-1:0]    rem_q;
  logic [NUM_CHAN-1:0][MEAN_W-1:0]   quo_q;

  assign done_o = done_q;
  assign mean_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= run_q && (step_q == '0);
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= QUO_STEP_W'(MEAN_W - 1);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // The quotient fits MEAN_W bits, so start with the divisor shifted up by MEAN_W-1.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= {{PAD_W{1'b0}}, count_i, {(MEAN_W - 1){1'b0}}};
      rem_q <= sum_i;
    end else if (run_q) begin
      div_q <= div_q >> 1;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        if (rem_q[ch] >= div_q) begin
          rem_q[ch] <= rem_q[ch] - div_q;
          quo_q[ch] <= {quo_q[ch][MEAN_W-2:0], 1'b1};
        end else begin
          quo_q[ch] <= {quo_q[ch][MEAN_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rgb_histogram_with_mean_rotation_unit.sv */
// Top level of the RGB histogram block with mean computation and rotation.
//
// Usage:
//   Input beats arrive on the s_axis group: tuser carries the item kind
//   (clear, pixel, finish, rotate, read), tdata the pixel values, the read bin
//   and the rotation target. Results leave on the m_axis group: tuser is 1 for
//   a mean result and 0 for a bin read result.
//   Pixels are taken one per cycle while the input is not held off; each one
//   does a read-modify-write of three bin memories (registered read, the write
//   of the previous cycle forwarded to the next read), so back-to-back pixels
//   on one bin count right. A read beat's result passes the registered bin read
//   and then the output register; the input holds ready low in the cycle after a
//   read while its counts are fetched. A finish beat runs the divider for all
//   three channels and gives the means when it is done; no beat is taken
//   meanwhile. After reset, and after each clear beat, a clearing pass zeroes
//   the bin memories one entry per cycle, with ready low until it is done.
//   Results wait in one output register; while it is full and the receiver
//   stalls, the input keeps ready low, so no result is ever dropped.
//   Rotation does not move data: a logical bin maps to a physical bin through
//   a held offset, applied on every pixel and read access.
`default_nettype none

`include "rgb_histogram_with_mean_rotation_unit_assert.svh"

module rgb_histogram_with_mean_rotation_unit
  import rgbh_pkg::*;
#(
  parameter int unsigned BIN_COUNT  = 256,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // red_value[7:0], green_value[15:8], blue_value[23:16], read_bin[31:24],
  // target_mean_bin[39:32]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind[2:0]
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // count_red[23:0], count_green[47:24], count_blue[71:48], mean_red[79:72],
  // mean_green[87:80], mean_blue[95:88], empty_image[96], zero[103:97]
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // is_means[0]
  output logic      [OUT_TUSER_W-1:0] m_axis_tuser_o
);

  localparam int unsigned IDX_W = $clog2(BIN_COUNT);
  localparam int unsigned BIN_W = IDX_W + 1;
  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - NUM_CHAN * (OUT_CNT_W + MEAN_W) - 1;

  typedef logic [VALUE_RANGE-1:0][IDX_W-1:0] fold_tbl_t;

  // Channel values reduced modulo the bin count, worked out at elaboration.
  function automatic fold_tbl_t build_fold();
    fold_tbl_t t;
    for (int i = 0; i < VALUE_RANGE; i++) begin
      t[i] = IDX_W'(i % BIN_COUNT);
    end
    return t;
  endfunction

  localparam fold_tbl_t FOLD = build_fold();

  function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [BIN_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= BIN_W'(BIN_COUNT)) begin
      s = s - BIN_W'(BIN_COUNT);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] mod_sub(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [BIN_W-1:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + BIN_W'(BIN_COUNT) - {1'b0, b};
    end
    return s[IDX_W-1:0];
  endfunction

  // Input unpacking
  kind_e                in_kind;
  logic [VALUE_W-1:0]   in_red, in_green, in_blue, in_read_bin, in_target;
  logic                 acc;

  assign in_kind     = kind_e'(s_axis_tuser_i);
  assign in_red      = s_axis_tdata_i[7:0];
  assign in_green    = s_axis_tdata_i[15:8];
  assign in_blue     = s_axis_tdata_i[23:16];
  assign in_read_bin = s_axis_tdata_i[31:24];
  assign in_target   = s_axis_tdata_i[39:32];
  assign acc         = s_axis_tvalid_i && s_axis_tready_o;

  // Control state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q;
  logic             clr_last;
  logic             clr_en;
  logic             run;
  logic             s2_result_q;

  // Running totals and rotation
  logic [NUM_CHAN-1:0][SUM_W-1:0] sum_q, sum_d;
  logic [PIX_CNT_W-1:0]           pixel_count_q, pixel_count_d;
  logic [MEAN_W-1:0]              mean_held_q, mean_held_d;
  logic [IDX_W-1:0]               offset_q, offset_d;
  logic                           div_start;
  logic                           div_empty_q;
  logic                           div_done;
  logic [NUM_CHAN-1:0][MEAN_W-1:0] div_mean;

  // Bin access
  bin_ctrl_t                           bin_ctrl;
  logic [NUM_CHAN-1:0][IDX_W-1:0]      chan_phys;
  logic [NUM_CHAN-1:0][IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]                    read_phys;
  logic [NUM_CHAN-1:0][COUNT_BITS-1:0] bin_count;
  logic [NUM_CHAN-1:0][CNT_WIDE_W-1:0] bin_wide;

  // Output register
  logic                              out_valid_q;
  logic                              out_is_means_q;
  logic [NUM_CHAN-1:0][OUT_CNT_W-1:0] out_count_q;
  logic [NUM_CHAN-1:0][MEAN_W-1:0]   out_mean_q;
  logic                              out_empty_q;

  assign clr_last = (clr_cnt_q == IDX_W'(BIN_COUNT - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (acc && (in_kind == KIND_FINISH)) begin
          state_d = ST_DIV;
        end else if (acc && (in_kind == KIND_CLEAR)) begin
          state_d = ST_CLEAR;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    clr_en = 1'b0;
    run    = 1'b0;
    unique case (state_q)
      ST_CLEAR: clr_en = 1'b1;
      ST_RUN:   run    = 1'b1;
      ST_DIV:   run    = 1'b0;
      default:  run    = 1'b0;
    endcase
  end

  // Hold off input outside the run state, while a read is in flight, or while a result waits on a stalled receiver.
  assign s_axis_tready_o = run && !s2_result_q && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      s2_result_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s2_result_q <= acc && (in_kind == KIND_READ);
      if (clr_en) begin
        clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
      end
    end
  end

  // Logical to physical bin mapping through the rotation offset
  assign chan_phys[0] = mod_add(FOLD[in_red], offset_q);
  assign chan_phys[1] = mod_add(FOLD[in_green], offset_q);
  assign chan_phys[2] = mod_add(FOLD[in_blue], offset_q);
  assign read_phys    = mod_add(FOLD[in_read_bin], offset_q);

  always_comb begin
    bin_ctrl.rd_en  = acc && ((in_kind == KIND_PIXEL) || (in_kind == KIND_READ));
    bin_ctrl.bump   = (in_kind == KIND_PIXEL);
    bin_ctrl.clr_en = clr_en;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      rd_addr[ch] = (in_kind == KIND_READ) ? read_phys : chan_phys[ch];
    end
  end

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_chan
    rgbh_bin_rmw #(
      .BIN_COUNT  (BIN_COUNT),
      .COUNT_BITS (COUNT_BITS)
    ) u_bins (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (bin_ctrl),
      .rd_addr_i  (rd_addr[ch]),
      .clr_addr_i (clr_cnt_q),
      .count_o    (bin_count[ch])
    );
    assign bin_wide[ch] = CNT_WIDE_W'(bin_count[ch]);
  end

  // Sums, pixel count, held mean and offset
  always_comb begin
    sum_d         = sum_q;
    pixel_count_d = pixel_count_q;
    mean_held_d   = mean_held_q;
    offset_d      = offset_q;
    div_start     = 1'b0;
    if (acc) begin
      unique case (in_kind)
        KIND_CLEAR: begin
          sum_d         = '0;
          pixel_count_d = '0;
          mean_held_d   = '0;
          offset_d      = '0;
        end
        KIND_PIXEL: begin
          // Stop accumulating once the count saturates, so the sums never wrap.
          if (pixel_count_q != PIX_CNT_MAX) begin
            sum_d[0]      = sum_q[0] + SUM_W'(in_red);
            sum_d[1]      = sum_q[1] + SUM_W'(in_green);
            sum_d[2]      = sum_q[2] + SUM_W'(in_blue);
            pixel_count_d = pixel_count_q + 1'b1;
          end
        end
        KIND_FINISH: begin
          div_start     = 1'b1;
          sum_d         = '0;
          pixel_count_d = '0;
        end
        KIND_ROTATE: begin
          offset_d = mod_sub(mod_add(offset_q, FOLD[mean_held_q]), FOLD[in_target]);
        end
        KIND_READ: begin
          offset_d = offset_q;
        end
        default: begin
          offset_d = offset_q;
        end
      endcase
    end
    if (div_done) begin
      mean_held_d = div_empty_q ? '0 : div_mean[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q         <= '0;
      pixel_count_q <= '0;
      mean_held_q   <= '0;
      offset_q      <= '0;
    end else begin
      sum_q         <= sum_d;
      pixel_count_q <= pixel_count_d;
      mean_held_q   <= mean_held_d;
      offset_q      <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_empty_q <= (pixel_count_q == '0);
    end
  end

  rgbh_mean_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_q),
    .count_i (pixel_count_q),
    .done_o  (div_done),
    .mean_o  (div_mean)
  );

  // Output register: load a read result or the means, drop when the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_result_q || div_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_result_q) begin
      out_is_means_q <= 1'b0;
      out_empty_q    <= 1'b0;
      out_mean_q     <= '0;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        out_count_q[ch] <= bin_wide[ch][OUT_CNT_W-1:0];
      end
    end else if (div_done) begin
      out_is_means_q <= 1'b1;
      out_empty_q    <= div_empty_q;
      out_count_q    <= '0;
      out_mean_q     <= div_empty_q ? '0 : div_mean;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_is_means_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_empty_q,
                            out_mean_q[2], out_mean_q[1], out_mean_q[0],
                            out_count_q[2], out_count_q[1], out_count_q[0]};

  // A finished division always finds the output register free.
  `RGBH_ASSERT_NOW(a_div_out_free, clk_i, rst_ni, div_done, !out_valid_q)
  // A fetched read result never lands on an occupied output register.
  `RGBH_ASSERT_NOW(a_read_out_free, clk_i, rst_ni, s2_result_q, !out_valid_q)
  // During the clearing pass the count and the rotation are already back at zero.
  `RGBH_ASSERT_NOW(a_clear_state, clk_i, rst_ni, state_q == ST_CLEAR,
                   (pixel_count_q == '0) && (offset_q == '0))
  // A finish beat sends the block into the division for the next cycle.
  `RGBH_ASSERT_NEXT(a_finish_div, clk_i, rst_ni, acc && (in_kind == KIND_FINISH),
                    (state_q == ST_DIV) && !s_axis_tready_o)

endmodule

`default_nettype wire

/* tb/sv/rgb_histogram_with_mean_rotation_unit_tb.sv */
// Testbench for the RGB histogram unit: directed table, then random images checked by a predictor.
`timescale 1ns / 100ps

module rgb_histogram_with_mean_rotation_unit_tb;
  import rgbh_pkg::*;

  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned HOLD_CYCLES  = 400;  // long receiver stall that backs up the input
  localparam int unsigned HOLD_SPACING = 80;   // results between two long stalls
  localparam int unsigned DRAIN_CYCLES = 300;  // covers a trailing clearing pass
  localparam int unsigned TIMEOUT_NS   = 10_000_000;

  // Kinds the block must swallow without a result.
  localparam logic [IN_TUSER_W-1:0] KIND_IGNORED_FIRST = 3'd5;
  localparam logic [IN_TUSER_W-1:0] KIND_IGNORED_MID   = 3'd6;
  localparam logic [IN_TUSER_W-1:0] KIND_IGNORED_LAST  = 3'd7;

  localparam logic [OUT_CNT_W-1:0] BIN_FULL = '1;

  // One result beat, field by field.
  typedef struct packed {
    logic                 is_means;
    logic [OUT_CNT_W-1:0] count_red;
    logic [OUT_CNT_W-1:0] count_green;
    logic [OUT_CNT_W-1:0] count_blue;
    logic [MEAN_W-1:0]    mean_red;
    logic [MEAN_W-1:0]    mean_green;
    logic [MEAN_W-1:0]    mean_blue;
    logic                 empty_image;
  } hist_result_t;

  // One input beat; fixed marks a row whose result is typed into the table.
  typedef struct packed {
    logic [IN_TUSER_W-1:0] kind;
    logic [VALUE_W-1:0]    red;
    logic [VALUE_W-1:0]    green;
    logic [VALUE_W-1:0]    blue;
    logic [VALUE_W-1:0]    read_bin;
    logic [VALUE_W-1:0]    target;
    logic                  fixed;
    hist_result_t          want;
  } hist_beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  wire                    s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic [IN_TUSER_W-1:0]  s_axis_tuser_i;
  wire                    m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata_o;
  wire  [OUT_TUSER_W-1:0] m_axis_tuser_o;

  // Predictor state: logical bins live at physical (bin + bin_offset) mod 256.
  logic [OUT_CNT_W-1:0] red_hist   [VALUE_RANGE];
  logic [OUT_CNT_W-1:0] green_hist [VALUE_RANGE];
  logic [OUT_CNT_W-1:0] blue_hist  [VALUE_RANGE];
  logic [SUM_W-1:0]     red_total, green_total, blue_total;
  logic [PIX_CNT_W-1:0] pixels_in_image;
  logic [MEAN_W-1:0]    red_mean_kept;
  logic [VALUE_W-1:0]   bin_offset;

  hist_result_t pending_readouts[$];
  hist_beat_t   table_rows[$];

  int unsigned beats_counted;
  int unsigned kind_seen [8];
  int unsigned results_seen;
  int unsigned long_holds;
  int unsigned mismatches;
  int unsigned gap_calm_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_histogram_with_mean_rotation_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Zero bins, sums, pixel count, held mean and offset.
  function automatic void clear_histograms();
    for (int i = 0; i < VALUE_RANGE; i++) begin
      red_hist[i]   = '0;
      green_hist[i] = '0;
      blue_hist[i]  = '0;
    end
    red_total       = '0;
    green_total     = '0;
    blue_total      = '0;
    pixels_in_image = '0;
    red_mean_kept   = '0;
    bin_offset      = '0;
  endfunction

  // Advance the predicted histograms by one accepted beat and return its result, if any.
  function automatic void apply_to_histograms(input hist_beat_t b, output bit gives,
                                              output hist_result_t res);
    logic [VALUE_W-1:0] idx_r, idx_g, idx_b;
    gives = 1'b0;
    res   = '0;
    case (b.kind)
      KIND_CLEAR: clear_histograms();
      KIND_PIXEL: begin
        idx_r = b.red + bin_offset;
        idx_g = b.green + bin_offset;
        idx_b = b.blue + bin_offset;
        // bins saturate; the sums stop once the pixel count is full
        if (red_hist[idx_r] != BIN_FULL) red_hist[idx_r] = red_hist[idx_r] + 1'b1;
        if (green_hist[idx_g] != BIN_FULL) green_hist[idx_g] = green_hist[idx_g] + 1'b1;
        if (blue_hist[idx_b] != BIN_FULL) blue_hist[idx_b] = blue_hist[idx_b] + 1'b1;
        if (pixels_in_image != PIX_CNT_MAX) begin
          red_total       = red_total + b.red;
          green_total     = green_total + b.green;
          blue_total      = blue_total + b.blue;
          pixels_in_image = pixels_in_image + 1'b1;
        end
      end
      KIND_FINISH: begin
        gives        = 1'b1;
        res.is_means = 1'b1;
        if (pixels_in_image == '0) begin
          res.empty_image = 1'b1;
          red_mean_kept   = '0;
        end else begin
          res.mean_red   = MEAN_W'(red_total / SUM_W'(pixels_in_image));
          res.mean_green = MEAN_W'(green_total / SUM_W'(pixels_in_image));
          res.mean_blue  = MEAN_W'(blue_total / SUM_W'(pixels_in_image));
          red_mean_kept  = res.mean_red;
        end
        red_total       = '0;
        green_total     = '0;
        blue_total      = '0;
        pixels_in_image = '0;
      end
      // turn left by (held red mean - target), wrapping at 256
      KIND_ROTATE: bin_offset = bin_offset + red_mean_kept - b.target;
      KIND_READ: begin
        idx_r           = b.read_bin + bin_offset;
        gives           = 1'b1;
        res.count_red   = red_hist[idx_r];
        res.count_green = green_hist[idx_r];
        res.count_blue  = blue_hist[idx_r];
      end
      default: ;
    endcase
  endfunction

  function automatic hist_beat_t row(input logic [IN_TUSER_W-1:0] kind,
                                     input logic [VALUE_W-1:0] red, green, blue,
                                     input logic [VALUE_W-1:0] read_bin, target);
    hist_beat_t b;
    b          = '0;
    b.kind     = kind;
    b.red      = red;
    b.green    = green;
    b.blue     = blue;
    b.read_bin = read_bin;
    b.target   = target;
    return b;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input hist_beat_t b);
    table_rows.insert(table_rows.size(), b);
  endfunction

  // Type in the counts a read row must return.
  function automatic hist_beat_t with_counts(input hist_beat_t b,
                                             input logic [OUT_CNT_W-1:0] cr, cg, cb);
    b.fixed            = 1'b1;
    b.want             = '0;
    b.want.count_red   = cr;
    b.want.count_green = cg;
    b.want.count_blue  = cb;
    return b;
  endfunction

  // Type in the means a finish row must return.
  function automatic hist_beat_t with_means(input hist_beat_t b,
                                            input logic [MEAN_W-1:0] mr, mg, mb,
                                            input logic empty);
    b.fixed            = 1'b1;
    b.want             = '0;
    b.want.is_means    = 1'b1;
    b.want.mean_red    = mr;
    b.want.mean_green  = mg;
    b.want.mean_blue   = mb;
    b.want.empty_image = empty;
    return b;
  endfunction

  // Crowd values into the four bins at each end so counts climb and repeat back to back.
  function automatic logic [VALUE_W-1:0] near_edge();
    if ($urandom_range(0, 1)) return VALUE_W'($urandom_range(0, 3));
    return VALUE_W'($urandom_range(VALUE_RANGE - 4, VALUE_RANGE - 1));
  endfunction

  // Random content in every field, used by the block or not.
  function automatic hist_beat_t rand_beat(input logic [IN_TUSER_W-1:0] kind);
    hist_beat_t b;
    b = row(kind, VALUE_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom),
            VALUE_W'($urandom), VALUE_W'($urandom));
    if (kind == KIND_PIXEL && $urandom_range(0, 1)) begin
      b.red   = near_edge();
      b.green = near_edge();
      b.blue  = near_edge();
    end
    if (kind == KIND_READ && $urandom_range(0, 1)) b.read_bin = near_edge();
    return b;
  endfunction

  // Offer one beat after a random gap, hold it until accepted, then predict its result.
  task automatic send_beat(input hist_beat_t b);
    int unsigned  gap;
    int unsigned  pick;
    bit           gives;
    hist_result_t res;
    if (gap_calm_left > 0) begin
      gap = 0;
      gap_calm_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        gap_calm_left = $urandom_range(20, 60);
        gap = 0;
      end else if (pick < 55) begin
        gap = 0;
      end else if (pick < 90) begin
        gap = $urandom_range(1, 3);
      end else if (pick < 97) begin
        gap = $urandom_range(4, 10);
      end else begin
        gap = $urandom_range(20, 60);
      end
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b.target, b.read_bin, b.blue, b.green, b.red};
    s_axis_tuser_i  <= b.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    kind_seen[b.kind]++;
    if (b.kind < KIND_IGNORED_FIRST) beats_counted++;
    apply_to_histograms(b, gives, res);
    if (gives) pending_readouts.insert(pending_readouts.size(), b.fixed ? b.want : res);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one accepted result beat with the oldest outstanding expectation.
  task automatic take_result(input logic [OUT_TUSER_W-1:0] user,
                             input logic [OUT_TDATA_W-1:0] data);
    hist_result_t want;
    results_seen++;
    if (pending_readouts.size() == 0) begin
      $error("result beat with nothing outstanding: tuser %0d tdata %h", user, data);
      mismatches++;
    end else begin
      want = pending_readouts.pop_front();
      check_field("is_means",    want.is_means,    user[0]);
      check_field("count_red",   want.count_red,   data[23:0]);
      check_field("count_green", want.count_green, data[47:24]);
      check_field("count_blue",  want.count_blue,  data[71:48]);
      check_field("mean_red",    want.mean_red,    data[79:72]);
      check_field("mean_green",  want.mean_green,  data[87:80]);
      check_field("mean_blue",   want.mean_blue,   data[95:88]);
      check_field("empty_image", want.empty_image, data[96]);
    end
  endtask

  // Result side: check every accepted beat, stall tready at random, and now and then
  // hold it low for a long stretch so the output register fills and the input backs up.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned pick;
    int unsigned next_hold_at;
    stall_left      = 0;
    calm_left       = 0;
    next_hold_at    = 20;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) take_result(m_axis_tuser_o, m_axis_tdata_o);
      if (stall_left == 0 && results_seen >= next_hold_at) begin
        stall_left   = HOLD_CYCLES;
        next_hold_at = next_hold_at + HOLD_SPACING;
        long_holds++;
      end else if (stall_left == 0) begin
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 2) calm_left = $urandom_range(20, 60);
          else if (pick < 22) stall_left = $urandom_range(1, 3);
          else if (pick < 25) stall_left = $urandom_range(10, 40);
        end
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned n_pix;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_CLEAR;
    gap_calm_left   = 0;
    clear_histograms();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. Typed results: empty state after reset, empty images, the two
    // extreme bins, and a three-pixel image whose means are easy to work out by hand.
    add_row(with_counts(row(KIND_READ,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 0, 0));
    add_row(with_counts(row(KIND_READ,   8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 0, 0, 0));
    add_row(with_means(row(KIND_FINISH,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                       0, 0, 0, 1'b1));
    add_row(row(KIND_PIXEL,              8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    add_row(row(KIND_PIXEL,              8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    add_row(row(KIND_PIXEL,              8'hff, 8'h00, 8'h80, 8'h00, 8'h00));
    add_row(with_counts(row(KIND_READ,   8'h00, 8'h00, 8'h00, 8'hff, 8'h00), 2, 1, 1));
    add_row(with_counts(row(KIND_READ,   8'hff, 8'hff, 8'hff, 8'h00, 8'hff), 1, 2, 1));
    add_row(with_means(row(KIND_FINISH,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                       170, 85, 127, 1'b0));
    // rotate so the red mean lands on bin 0, then read through the offset
    add_row(row(KIND_ROTATE,             8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    add_row(row(KIND_READ,               8'h00, 8'h00, 8'h00, 8'd86, 8'h00));
    add_row(row(KIND_READ,               8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // unknown kinds must leave no trace
    add_row(row(KIND_IGNORED_FIRST,      8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    add_row(row(KIND_IGNORED_MID,        8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    add_row(row(KIND_IGNORED_LAST,       8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    add_row(row(KIND_PIXEL,              8'haa, 8'h55, 8'h0f, 8'h55, 8'haa));
    add_row(row(KIND_PIXEL,              8'h55, 8'haa, 8'hf0, 8'haa, 8'h55));
    add_row(row(KIND_FINISH,             8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    add_row(row(KIND_ROTATE,             8'h00, 8'h00, 8'h00, 8'h00, 8'hff));
    add_row(row(KIND_READ,               8'h00, 8'h00, 8'h00, 8'haa, 8'h00));
    add_row(with_means(row(KIND_FINISH,  8'hff, 8'hff, 8'hff, 8'hff, 8'hff),
                       0, 0, 0, 1'b1));
    // rotate with a zero held mean, then clear everything including the offset
    add_row(row(KIND_ROTATE,             8'h00, 8'h00, 8'h00, 8'h00, 8'h01));
    add_row(row(KIND_CLEAR,              8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    add_row(with_counts(row(KIND_READ,   8'h00, 8'h00, 8'h00, 8'h55, 8'h00), 0, 0, 0));
    add_row(with_means(row(KIND_FINISH,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                       0, 0, 0, 1'b1));
    foreach (table_rows[i]) send_beat(table_rows[i]);

    // Random images: a run of pixels with some noise mixed in, its finish, maybe a
    // rotation, a few reads, and now and then a clear.
    while (beats_counted < table_rows.size() + RANDOM_ITEMS) begin
      n_pix = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      if ($urandom_range(0, 19) == 0) n_pix = $urandom_range(60, 120);
      repeat (n_pix) begin
        send_beat(rand_beat(KIND_PIXEL));
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       send_beat(rand_beat(KIND_READ));
            1:       send_beat(rand_beat(KIND_ROTATE));
            2:       send_beat(rand_beat(KIND_FINISH));
            default: send_beat(rand_beat(IN_TUSER_W'($urandom_range(KIND_IGNORED_FIRST,
                                                                    KIND_IGNORED_LAST))));
          endcase
        end
      end
      send_beat(rand_beat(KIND_FINISH));
      if ($urandom_range(0, 1)) send_beat(rand_beat(KIND_ROTATE));
      repeat ($urandom_range(0, 4)) send_beat(rand_beat(KIND_READ));
      if ($urandom_range(0, 24) == 0) send_beat(rand_beat(KIND_CLEAR));
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain outstanding results, then idle long enough for a trailing clear pass
    // or a stray extra beat to show up.
    while (pending_readouts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: sent %0d beats: %0d pixel, %0d finish, %0d rotate, %0d read, %0d clear, %0d unknown",
             beats_counted + kind_seen[KIND_IGNORED_FIRST] + kind_seen[KIND_IGNORED_MID]
               + kind_seen[KIND_IGNORED_LAST],
             kind_seen[KIND_PIXEL], kind_seen[KIND_FINISH], kind_seen[KIND_ROTATE],
             kind_seen[KIND_READ], kind_seen[KIND_CLEAR],
             kind_seen[KIND_IGNORED_FIRST] + kind_seen[KIND_IGNORED_MID]
               + kind_seen[KIND_IGNORED_LAST]);
    $display("tb: checked %0d result beats, %0d long output holds, %0d mismatches",
             results_seen, long_holds, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
